FILE: src/vcr_pkg.sv
// ============================================================================
// vcr_pkg
// Shared types and constants for the volume crescendo ramp unit.
// ============================================================================
package vcr_pkg;

    // item function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [6:0]  VOL_MAX  = 7'd127;
    localparam logic [6:0]  VOL_MIN  = 7'd0;
    localparam logic [16:0] STEP_MAX = 17'h1FFFF;

    // one ramp table entry
    typedef struct packed {
        logic [16:0]        step_count;
        logic [15:0]        ramp_steps;
        logic signed [7:0]  ramp_delta;
        logic signed [7:0]  applied_level;
        logic               ramp_active;
    } entry_t;

endpackage

FILE: src/volume_crescendo_ramp_unit.sv
// ============================================================================
// volume_crescendo_ramp_unit
// Per-sequence linear volume ramp engine. A table of ramps, one per
// separation/sequence pair, sits in a memory with a single write port and a
// registered read; each item reads its entry, updates it and writes it back.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | input     | in_valid / in_stall | func, sep_index, seq_index,
//          |           |                     | total_steps, total_delta,
//          |           |                     | left_vol, right_vol
//  out     | output    | out_valid/out_stall | new_left, new_right,
//          |           |                     | vol_changed, active
//
//  - A tick that reaches the ramp math goes through accept, entry read,
//    multiply, 8 restoring divide steps and write-back. Start items, idle
//    ticks, ended ramps and out-of-range indexes skip multiply and divide.
//  - The divide unit makes one quotient bit per cycle.
//  - After reset a clearing pass writes every entry to zero, one per cycle,
//    with in_stall held high.
//  - A finished item sits in the output register; the next item is taken
//    while it waits, but write-back of that next item waits for the slot.
//
module volume_crescendo_ramp_unit #(
    parameter int SEPARATIONS = 16,
    parameter int SEQUENCES   = 16
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [3:0]        sep_index,
    input  logic [3:0]        seq_index,
    input  logic [15:0]       total_steps,
    input  logic signed [7:0] total_delta,
    input  logic [6:0]        left_vol,
    input  logic [6:0]        right_vol,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [6:0]        new_left,
    output logic [6:0]        new_right,
    output logic              vol_changed,
    output logic              active
);

    localparam int ENTRIES = SEPARATIONS * SEQUENCES;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // item and datapath registers (no reset)
    // ------------------------------------------------------------------
    logic              func_reg;
    logic [15:0]       steps_in_reg;
    logic signed [7:0] delta_in_reg;
    logic [6:0]        left_reg;
    logic [6:0]        right_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              in_range_reg;

    vcr_pkg::entry_t   rd_word_reg;            // memory read data
    vcr_pkg::entry_t   word_reg, word_next;    // entry being updated
    logic              calc_reg, calc_next;    // tick needs the ramp math
    logic              wr_reg, wr_next;        // entry gets written back
    logic              neg_reg, neg_next;      // sign of delta*step
    logic [24:0]       rem_reg, rem_next;      // dividend / remainder
    logic [24:0]       dvs_reg, dvs_next;      // shifted divisor
    logic [7:0]        q_reg, q_next;          // quotient magnitude
    logic [2:0]        cnt_reg, cnt_next;      // divide step

    logic [6:0]        new_left_reg, new_right_reg;
    logic              vol_changed_reg, active_reg;

    // ------------------------------------------------------------------
    // ramp table
    // ------------------------------------------------------------------
    vcr_pkg::entry_t   mem [ENTRIES];

    logic              accept;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    vcr_pkg::entry_t   wr_data;

    logic [31:0]       entry_wide;
    logic              idx_ok;
    logic              fin_go;

    // write-back math
    logic [16:0]       step_new;
    logic [7:0]        mag;
    logic signed [8:0] target;
    logic signed [9:0] inc;
    logic signed [9:0] lsum, rsum;
    logic [6:0]        lclamp, rclamp;
    vcr_pkg::entry_t   fin_word;
    logic [6:0]        fin_left, fin_right;
    logic              fin_changed;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign entry_wide = 32'(sep_index) * 32'(SEQUENCES) + 32'(seq_index);
    assign idx_ok     = (32'(sep_index) < 32'(SEPARATIONS)) &&
                        (32'(seq_index) < 32'(SEQUENCES));
    assign rd_en      = accept;
    assign rd_addr    = idx_ok ? entry_wide[ADDR_W-1:0] : '0;
    assign fin_go     = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = fin_word;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (fin_go && wr_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // entry update on a tick: saturating step, then math or end of ramp
    // ------------------------------------------------------------------
    assign step_new = (rd_word_reg.step_count == vcr_pkg::STEP_MAX) ?
                      rd_word_reg.step_count : rd_word_reg.step_count + 17'd1;

    // |delta|; -128 comes out as 8'h80
    assign mag = word_reg.ramp_delta[7] ? 8'(-word_reg.ramp_delta) :
                 8'(word_reg.ramp_delta);

    // final step: signed target, change since last applied level, clamps
    assign target = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign inc    = 10'(target) - 10'(word_reg.applied_level);
    assign lsum   = $signed({3'b000, left_reg}) + inc;
    assign rsum   = $signed({3'b000, right_reg}) + inc;

    always_comb
    begin
        if (lsum < 0)
            lclamp = vcr_pkg::VOL_MIN;
        else if (lsum > 10'sd127)
            lclamp = vcr_pkg::VOL_MAX;
        else
            lclamp = lsum[6:0];
        if (rsum < 0)
            rclamp = vcr_pkg::VOL_MIN;
        else if (rsum > 10'sd127)
            rclamp = vcr_pkg::VOL_MAX;
        else
            rclamp = rsum[6:0];
    end

    always_comb
    begin
        fin_word    = word_reg;
        fin_left    = left_reg;
        fin_right   = right_reg;
        fin_changed = 1'b0;
        if (calc_reg && (inc != 10'sd0))
        begin
            fin_word.applied_level = target[7:0];
            fin_left    = lclamp;
            fin_right   = rclamp;
            fin_changed = 1'b1;
            // both pinned at the same rail ends the ramp
            if (((lclamp == vcr_pkg::VOL_MAX) && (rclamp == vcr_pkg::VOL_MAX)) ||
                ((lclamp == vcr_pkg::VOL_MIN) && (rclamp == vcr_pkg::VOL_MIN)))
            begin
                fin_word.ramp_active = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        calc_next      = calc_reg;
        wr_next        = wr_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                word_next  = rd_word_reg;
                calc_next  = 1'b0;
                wr_next    = 1'b0;
                state_next = S_FIN;
                if (!in_range_reg)
                begin
                    word_next.ramp_active = 1'b0;
                end
                else if (func_reg == vcr_pkg::FUNC_START)
                begin
                    word_next.step_count    = '0;
                    word_next.ramp_steps    = steps_in_reg;
                    word_next.ramp_delta    = delta_in_reg;
                    word_next.applied_level = '0;
                    word_next.ramp_active   = 1'b1;
                    wr_next = 1'b1;
                end
                else if (rd_word_reg.ramp_active)
                begin
                    word_next.step_count = step_new;
                    wr_next = 1'b1;
                    if (step_new <= {1'b0, rd_word_reg.ramp_steps})
                    begin
                        calc_next  = 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        word_next.ramp_active = 1'b0;
                    end
                end
            end
            S_MUL:
            begin
                // step >= 1 here, so the product's sign is delta's sign
                neg_next   = word_reg.ramp_delta[7];
                rem_next   = {17'd0, mag} * {8'd0, word_reg.step_count};
                dvs_next   = {2'b00, word_reg.ramp_steps, 7'd0};
                q_next     = '0;
                cnt_next   = 3'd7;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // quotient fits 8 bits since step <= steps
                if (rem_reg >= dvs_reg)
                begin
                    rem_next = rem_reg - dvs_reg;
                    q_next   = {q_reg[6:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[6:0], 1'b0};
                end
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            steps_in_reg <= total_steps;
            delta_in_reg <= total_delta;
            left_reg     <= left_vol;
            right_reg    <= right_vol;
            addr_reg     <= rd_addr;
            in_range_reg <= idx_ok;
        end
        word_reg <= word_next;
        calc_reg <= calc_next;
        wr_reg   <= wr_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        if (fin_go)
        begin
            new_left_reg    <= fin_left;
            new_right_reg   <= fin_right;
            vol_changed_reg <= fin_changed;
            active_reg      <= in_range_reg && fin_word.ramp_active;
        end
    end

    assign out_valid   = out_valid_reg;
    assign new_left    = new_left_reg;
    assign new_right   = new_right_reg;
    assign vol_changed = vol_changed_reg;
    assign active      = active_reg;

`ifndef SYNTHESIS
    // an accepted item always goes to the entry evaluation next
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EVAL))
        else $error("accepted item did not reach evaluation");

    // a result only appears out of the write-back step
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside write-back");

    // an out-of-range item never touches the table
    a_no_wr_oob: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg == S_FIN)) |-> in_range_reg)
        else $error("table write for out-of-range index");

    // the divide quotient never exceeds 128, the largest |delta|
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && calc_reg) |-> (q_reg <= 8'd128))
        else $error("divide quotient out of range");

    // a waiting result is not overwritten
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(new_left_reg)
            && $stable(new_right_reg) && $stable(active_reg)))
        else $error("stalled result changed");
`endif

endmodule
